FILE: rtl/iff_pkg.sv
`timescale 1ns / 1ps
package iff_pkg;

  localparam int VALUE_BITS_DEF  = 64;
  localparam int DIGIT_DEPTH_DEF = 24;
  localparam int MAX_WIDTH_DEF   = 63;

  // digit count field holds values up to 127
  localparam int ND_W = 7;

  localparam logic [6:0] CH_SPACE = 7'd32;
  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_MINUS = 7'd45;
  localparam logic [6:0] CH_PLUS  = 7'd43;
  localparam logic [6:0] CH_LX    = 7'd120;
  localparam logic [6:0] CH_UX    = 7'd88;
  localparam logic [6:0] LET_UP   = 7'd55;
  localparam logic [6:0] LET_LO   = 7'd87;

  localparam int FL_LEFT  = 0;
  localparam int FL_ZERO  = 1;
  localparam int FL_PLUS  = 2;
  localparam int FL_SPACE = 3;
  localparam int FL_ALT   = 4;

  localparam logic [5:0] RADIX_MIN = 6'd8;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] RADIX_HEX = 6'd16;

  typedef struct packed {
    logic [63:0] value;
    logic [5:0]  radix;
    logic        negative;
    logic [5:0]  width;
    logic [4:0]  flags;
    logic        upper;
  } in_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       last;
  } out_t;

  // one formatted field waiting for the back end
  typedef struct packed {
    logic            bank;
    logic [ND_W-1:0] nd;
    logic [5:0]      pad;
    logic            has_sign;
    logic [6:0]      sign_ch;
    logic [1:0]      np;
    logic [6:0]      pre_ch;
    logic            left;
    logic            zero;
    logic            upper;
  } desc_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_FIN
  } fstate_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPAD,
    PH_SIGN,
    PH_PRE,
    PH_ZPAD,
    PH_DIG,
    PH_RPAD
  } phase_t;

  function automatic logic [6:0] digit_char(input logic [5:0] d, input logic up);
    logic [6:0] dd;
    dd = {1'b0, d};
    if (d < 6'd10) return CH_ZERO + dd;
    return (up ? LET_UP : LET_LO) + dd;
  endfunction

endpackage

FILE: rtl/iff_ram.sv
`timescale 1ns / 1ps
module iff_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/iff_front.sv
`timescale 1ns / 1ps
module iff_front #(
  parameter int VALUE_BITS  = iff_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_DEPTH = iff_pkg::DIGIT_DEPTH_DEF,
  parameter int MAX_WIDTH   = iff_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(2 * DIGIT_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  iff_pkg::in_t  item,
  output logic          busy,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [5:0]    ram_wdata,
  output logic          push,
  output iff_pkg::desc_t desc
);

  localparam int VB4   = ((VALUE_BITS + 3) / 4) * 4;
  localparam int STEPS = VB4 / 4;
  localparam int SW    = $clog2(STEPS);
  localparam int IW    = $clog2(DIGIT_DEPTH);
  localparam logic [AW-1:0] DEP_A = AW'(DIGIT_DEPTH);
  localparam logic [5:0] MW = 6'(MAX_WIDTH);
  localparam logic [iff_pkg::ND_W-1:0] ND_MAX = iff_pkg::ND_W'(DIGIT_DEPTH);

  iff_pkg::fstate_t st_r, st_nxt;
  logic [VB4-1:0] div_r, div_nxt;
  logic [5:0] rem_r, rem_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [iff_pkg::ND_W-1:0] nd_r, nd_nxt;
  logic bank_r, bank_nxt;
  logic [5:0] base_r, base_nxt;
  logic [5:0] w_r, w_nxt;
  logic [4:0] fl_r, fl_nxt;
  logic neg_r, neg_nxt;
  logic up_r, up_nxt;
  logic zv_r, zv_nxt;

  logic [5:0] r_d;
  logic [3:0] qb;
  logic [VB4-1:0] dv_next;
  logic last_step;

  // four restoring division bits per cycle, quotient shifts in from the bottom
  always_comb begin
    logic [6:0] t;
    r_d = rem_r;
    qb  = '0;
    for (int i = 0; i < 4; i++) begin
      t = {r_d, div_r[VB4-1-i]};
      if (t >= {1'b0, base_r}) begin
        r_d = 6'(t - {1'b0, base_r});
        qb[3-i] = 1'b1;
      end else begin
        r_d = t[5:0];
      end
    end
    dv_next = {div_r[VB4-5:0], qb};
  end

  assign last_step = (step_r == SW'(STEPS - 1));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      iff_pkg::FS_IDLE: if (acc) st_nxt = iff_pkg::FS_DIV;
      iff_pkg::FS_DIV:  if (last_step && dv_next == '0) st_nxt = iff_pkg::FS_FIN;
      iff_pkg::FS_FIN:  st_nxt = iff_pkg::FS_IDLE;
      default:          st_nxt = iff_pkg::FS_IDLE;
    endcase
  end

  always_comb begin
    logic [1:0] np;
    logic hs;
    logic [6:0] sch;
    logic [6:0] len;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    nd_nxt   = nd_r;
    bank_nxt = bank_r;
    base_nxt = base_r;
    w_nxt    = w_r;
    fl_nxt   = fl_r;
    neg_nxt  = neg_r;
    up_nxt   = up_r;
    zv_nxt   = zv_r;
    ram_we   = 1'b0;
    push     = 1'b0;
    busy     = (st_r != iff_pkg::FS_IDLE);

    case (st_r)
      iff_pkg::FS_IDLE: begin
        if (acc) begin
          div_nxt  = VB4'(item.value[VALUE_BITS-1:0]);
          zv_nxt   = (item.value[VALUE_BITS-1:0] == '0);
          rem_nxt  = '0;
          step_nxt = '0;
          nd_nxt   = '0;
          base_nxt = (item.radix < iff_pkg::RADIX_MIN) ? iff_pkg::RADIX_MIN :
                     (item.radix > iff_pkg::RADIX_MAX) ? iff_pkg::RADIX_MAX : item.radix;
          w_nxt    = (item.width > MW) ? MW : item.width;
          fl_nxt   = item.flags;
          neg_nxt  = item.negative;
          up_nxt   = item.upper;
        end
      end
      iff_pkg::FS_DIV: begin
        div_nxt = dv_next;
        if (last_step) begin
          ram_we   = (nd_r < ND_MAX);
          if (nd_r < ND_MAX) nd_nxt = nd_r + 1'b1;
          rem_nxt  = '0;
          step_nxt = '0;
        end else begin
          rem_nxt  = r_d;
          step_nxt = step_r + 1'b1;
        end
      end
      iff_pkg::FS_FIN: begin
        push     = 1'b1;
        bank_nxt = ~bank_r;
      end
      default: ;
    endcase

    hs  = neg_r | fl_r[iff_pkg::FL_PLUS] | fl_r[iff_pkg::FL_SPACE];
    sch = neg_r ? iff_pkg::CH_MINUS :
          fl_r[iff_pkg::FL_PLUS] ? iff_pkg::CH_PLUS : iff_pkg::CH_SPACE;
    np  = 2'd0;
    if (fl_r[iff_pkg::FL_ALT] && !zv_r) begin
      if (base_r == iff_pkg::RADIX_HEX) np = 2'd2;
      else if (base_r == iff_pkg::RADIX_MIN) np = 2'd1;
    end
    len = 7'(nd_r) + 7'(np) + 7'(hs);

    desc.bank     = bank_r;
    desc.nd       = nd_r;
    desc.pad      = ({1'b0, w_r} > len) ? 6'({1'b0, w_r} - len) : 6'd0;
    desc.has_sign = hs;
    desc.sign_ch  = sch;
    desc.np       = np;
    desc.pre_ch   = up_r ? iff_pkg::CH_UX : iff_pkg::CH_LX;
    desc.left     = fl_r[iff_pkg::FL_LEFT];
    desc.zero     = fl_r[iff_pkg::FL_ZERO];
    desc.upper    = up_r;
  end

  assign ram_wdata = r_d;
  assign ram_waddr = bank_r ? DEP_A + AW'(nd_r[IW-1:0]) : AW'(nd_r[IW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= iff_pkg::FS_IDLE;
      bank_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      bank_r <= bank_nxt;
    end
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    nd_r   <= nd_nxt;
    base_r <= base_nxt;
    w_r    <= w_nxt;
    fl_r   <= fl_nxt;
    neg_r  <= neg_nxt;
    up_r   <= up_nxt;
    zv_r   <= zv_nxt;
  end

endmodule

FILE: rtl/iff_queue.sv
`timescale 1ns / 1ps
module iff_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  iff_pkg::desc_t wdesc,
  input  logic           pop,
  output logic           valid,
  output iff_pkg::desc_t head,
  output logic [1:0]     cnt
);

  // two entries, one per digit store bank; an entry stays until its field is sent
  iff_pkg::desc_t ent_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
    if (push) ent_r[wp_r] <= wdesc;
  end

  assign valid = (cnt_r != 2'd0);
  assign head  = ent_r[rp_r];
  assign cnt   = cnt_r;

endmodule

FILE: rtl/iff_back.sv
`timescale 1ns / 1ps
module iff_back #(
  parameter int DIGIT_DEPTH = iff_pkg::DIGIT_DEPTH_DEF,
  localparam int AW = $clog2(2 * DIGIT_DEPTH)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  iff_pkg::desc_t q_head,
  output logic           pop,
  output logic           active,
  output logic [AW-1:0]  ram_raddr,
  input  logic [5:0]     ram_rdata,
  output logic           out_valid,
  output iff_pkg::out_t  out_data
);

  localparam int IW = $clog2(DIGIT_DEPTH);
  localparam logic [AW-1:0] DEP_A = AW'(DIGIT_DEPTH);

  iff_pkg::phase_t ph_r, ph_nxt;
  logic [6:0] cnt_r, cnt_nxt;

  iff_pkg::phase_t nx_ph;
  logic [6:0] nx_cnt;
  logic nx_none;

  logic emit, is_last, is_dig;
  logic [6:0] lit;
  logic [IW-1:0] didx;

  logic ov_r;
  logic [6:0] lit_r;
  logic isd_r, up_r, last_r;

  function automatic logic [6:0] phase_len(input iff_pkg::phase_t p,
                                           input iff_pkg::desc_t d);
    case (p)
      iff_pkg::PH_OPAD: return (!d.left && !d.zero) ? {1'b0, d.pad} : 7'd0;
      iff_pkg::PH_SIGN: return {6'd0, d.has_sign};
      iff_pkg::PH_PRE:  return {5'd0, d.np};
      iff_pkg::PH_ZPAD: return (!d.left && d.zero) ? {1'b0, d.pad} : 7'd0;
      iff_pkg::PH_DIG:  return 7'(d.nd);
      iff_pkg::PH_RPAD: return d.left ? {1'b0, d.pad} : 7'd0;
      default:          return 7'd0;
    endcase
  endfunction

  // first later phase of the field that has characters
  always_comb begin
    logic [6:0] n;
    iff_pkg::phase_t p;
    nx_ph   = iff_pkg::PH_IDLE;
    nx_cnt  = 7'd0;
    nx_none = 1'b1;
    for (int i = 1; i < 7; i++) begin
      p = iff_pkg::phase_t'(3'(i));
      n = phase_len(p, q_head);
      if (nx_none && (3'(i) > ph_r) && n != 7'd0) begin
        nx_ph   = p;
        nx_cnt  = n;
        nx_none = 1'b0;
      end
    end
  end

  always_comb begin
    ph_nxt  = ph_r;
    cnt_nxt = cnt_r;
    case (ph_r)
      iff_pkg::PH_IDLE: begin
        if (q_valid) begin
          ph_nxt  = nx_ph;
          cnt_nxt = nx_cnt;
        end
      end
      default: begin
        if (cnt_r == 7'd1) begin
          ph_nxt  = nx_ph;
          cnt_nxt = nx_cnt;
        end else begin
          cnt_nxt = cnt_r - 7'd1;
        end
      end
    endcase
  end

  always_comb begin
    emit    = (ph_r != iff_pkg::PH_IDLE);
    is_last = emit && (cnt_r == 7'd1) && nx_none;
    is_dig  = (ph_r == iff_pkg::PH_DIG);
    case (ph_r)
      iff_pkg::PH_SIGN: lit = q_head.sign_ch;
      iff_pkg::PH_PRE:  lit = (cnt_r == 7'd1 && q_head.np == 2'd2) ?
                              q_head.pre_ch : iff_pkg::CH_ZERO;
      iff_pkg::PH_ZPAD: lit = iff_pkg::CH_ZERO;
      default:          lit = iff_pkg::CH_SPACE;
    endcase
  end

  // digits go out most significant first: remaining count minus one
  assign didx      = IW'(cnt_r - 7'd1);
  assign ram_raddr = q_head.bank ? DEP_A + AW'(didx) : AW'(didx);
  assign pop       = is_last;
  assign active    = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= iff_pkg::PH_IDLE;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      ph_r  <= ph_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= emit;
    end
    lit_r  <= lit;
    isd_r  <= is_dig;
    up_r   <= q_head.upper;
    last_r <= is_last;
  end

  assign out_valid         = ov_r;
  assign out_data.char_out = isd_r ? iff_pkg::digit_char(ram_rdata, up_r) : lit_r;
  assign out_data.last     = last_r;

endmodule

FILE: rtl/integer_field_formatter_core.sv
`timescale 1ns / 1ps
// Formats an unsigned magnitude as a printf-style integer field (sign, 0/0x prefix,
// space or zero padding, radix 8..36) and sends it one ASCII character per cycle on
// out_data, with last set on the final one. Items are taken with start while busy is
// low. Digit extraction runs four division bits per cycle, and each digit needs a full
// pass of division steps over the value; a finishing state follows the last digit. The
// field then leaves at one character per cycle once the back end picks it up, after its
// phase register and the registered output stage. Conversion of the
// next item overlaps the sending of the previous field through a two-entry queue and
// a double-banked digit store; busy stays high while both banks are held. The
// receiver cannot stall: every character is shown for exactly one cycle with
// out_valid high and must be taken then.
module integer_field_formatter_core #(
  parameter int VALUE_BITS  = iff_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_DEPTH = iff_pkg::DIGIT_DEPTH_DEF,
  parameter int MAX_WIDTH   = iff_pkg::MAX_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  iff_pkg::in_t  in_data,
  output logic          out_valid,
  output iff_pkg::out_t out_data
);

  localparam int AW = $clog2(2 * DIGIT_DEPTH);

  logic acc, f_busy;
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [5:0] ram_wdata, ram_rdata;
  logic push, pop, q_valid, bk_active;
  logic [1:0] q_cnt;
  iff_pkg::desc_t f_desc, q_head;

  assign busy = f_busy || (q_cnt == 2'd2);
  assign acc  = start && !busy;

  iff_front #(
    .VALUE_BITS (VALUE_BITS),
    .DIGIT_DEPTH(DIGIT_DEPTH),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .item     (in_data),
    .busy     (f_busy),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .push     (push),
    .desc     (f_desc)
  );

  iff_ram #(
    .WIDTH(6),
    .DEPTH(2 * DIGIT_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  iff_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdesc(f_desc),
    .pop  (pop),
    .valid(q_valid),
    .head (q_head),
    .cnt  (q_cnt)
  );

  iff_back #(
    .DIGIT_DEPTH(DIGIT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .active   (bk_active),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  a_qcnt: assert property (@(posedge clk) disable iff (!rst_n) q_cnt != 2'd3)
    else $error("queue count overflow");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(bk_active))
    else $error("result without back end activity");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    bk_active |-> q_valid)
    else $error("back end active with empty queue");

endmodule
